@@ design/assert_macros.svh @@
// assertion macros shared by the tracker rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define CBT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define CBT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ design/cbt_pkg.sv @@
// package with constants and register codes of the blob tracker
`timescale 1ns / 1ps
package cbt_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int PIXEL_W        = 16;
  localparam int SERVO_W        = 11;
  localparam int CFG_DATA_W     = 11;
  localparam int CFG_INDEX_W    = 3;
  localparam int LINE_W         = 10;

  localparam logic [SERVO_W-1:0] SERVO_MAX = 11'd1999;
  localparam logic [PIXEL_W-1:0] OBJECT_MARK = 16'hFFFF;

  localparam logic [9:0]  LINE_WIDTH_RST   = 10'd220;
  localparam logic [4:0]  RED_MIN_RST      = 5'd15;
  localparam logic [5:0]  RG_MARGIN_RST    = 6'd6;
  localparam logic [4:0]  RB_MARGIN_RST    = 5'd6;
  localparam logic [9:0]  CENTER_LOW_RST   = 10'd105;
  localparam logic [9:0]  CENTER_HIGH_RST  = 10'd115;
  localparam logic [7:0]  LOST_STEP_RST    = 8'd5;
  localparam logic [10:0] SERVO_RESET_RST  = 11'd50;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LINE_WIDTH  = 3'd0,
    REG_RED_MIN     = 3'd1,
    REG_RG_MARGIN   = 3'd2,
    REG_RB_MARGIN   = 3'd3,
    REG_CENTER_LOW  = 3'd4,
    REG_CENTER_HIGH = 3'd5,
    REG_LOST_STEP   = 3'd6,
    REG_SERVO_RESET = 3'd7
  } cfg_reg_t;

endpackage

@@ design/cbt_pixel_if.sv @@
// pixel input channel
`timescale 1ns / 1ps
interface cbt_pixel_if import cbt_pkg::*;;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;
  logic               end_of_frame;

  modport source (output valid, pixel, end_of_frame, input ready);
  modport sink (input valid, pixel, end_of_frame, output ready);
endinterface

@@ design/cbt_result_if.sv @@
// result output channel
`timescale 1ns / 1ps
interface cbt_result_if import cbt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
);
  logic                  valid;
  logic                  ready;
  logic [PIXEL_W-1:0]    marked_pixel;
  logic                  frame_done;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic [SERVO_W-1:0]    servo_value;

  modport source (output valid, marked_pixel, frame_done, center_x, center_y, servo_value,
                  input ready);
  modport sink (input valid, marked_pixel, frame_done, center_x, center_y, servo_value,
                output ready);
endinterface

@@ design/color_blob_bbox_tracker.sv @@
// top level of the red blob bounding box tracker
//
//  channel  dir  payload
//  pixels   in   pixel, end_of_frame
//  results  out  marked_pixel, frame_done, center_x, center_y, servo_value
//  cfg      in   cfg_write, cfg_index, cfg_data
//
// one pixel per cycle unless the skid register is full; classification, box
// and servo update are done in the accept cycle; the result is registered
// a skid register behind the output keeps pixels flowing for one stalled item
// synchronous reset clears counters, box and queue and reloads the registers
`timescale 1ns / 1ps
module color_blob_bbox_tracker import cbt_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  cbt_pixel_if.sink              pixels,
  cbt_result_if.source           results
);

  `include "assert_macros.svh"

  localparam int CW    = COORD_BITS;
  localparam int CMP_W = (CW + 1 > LINE_W + 1) ? CW + 1 : LINE_W + 1;

  // configuration
  logic [9:0]  line_width;
  logic [4:0]  red_min;
  logic [5:0]  red_green_margin;
  logic [4:0]  red_blue_margin;
  logic [9:0]  center_low;
  logic [9:0]  center_high;
  logic [7:0]  lost_step;
  logic [10:0] servo_reset;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width       <= LINE_WIDTH_RST;
      red_min          <= RED_MIN_RST;
      red_green_margin <= RG_MARGIN_RST;
      red_blue_margin  <= RB_MARGIN_RST;
      center_low       <= CENTER_LOW_RST;
      center_high      <= CENTER_HIGH_RST;
      lost_step        <= LOST_STEP_RST;
      servo_reset      <= SERVO_RESET_RST;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_LINE_WIDTH:  line_width       <= cfg_data[9:0];
        REG_RED_MIN:     red_min          <= cfg_data[4:0];
        REG_RG_MARGIN:   red_green_margin <= cfg_data[5:0];
        REG_RB_MARGIN:   red_blue_margin  <= cfg_data[4:0];
        REG_CENTER_LOW:  center_low       <= cfg_data[9:0];
        REG_CENTER_HIGH: center_high      <= cfg_data[9:0];
        REG_LOST_STEP:   lost_step        <= cfg_data[7:0];
        REG_SERVO_RESET: servo_reset      <= (cfg_data > SERVO_MAX) ? SERVO_MAX : cfg_data;
        default: ;
      endcase
    end
  end

  // frame state
  logic [CW-1:0]      column_count, row_count;
  logic               seen_object;
  logic [CW-1:0]      box_left, box_right, box_top, box_bottom;
  logic [SERVO_W-1:0] servo_position;

  logic [CW-1:0]      column_count_next, row_count_next;
  logic [CW-1:0]      box_left_next, box_right_next, box_top_next, box_bottom_next;
  logic [SERVO_W-1:0] servo_position_next;
  logic               obj;
  logic [CW-1:0]      cx, cy;
  logic               push, pop;

  logic [4:0] px_r, px_b;
  logic [5:0] px_g;
  logic signed [8:0] rg_diff, rg_limit;
  logic signed [6:0] rb_diff, rb_limit;
  logic [CW:0]       col_inc, sum_x, sum_y;
  logic [CMP_W-1:0]  cx_ext;
  logic [SERVO_W:0]  servo_sum;

  assign push = pixels.valid && pixels.ready;
  assign pop  = results.valid && results.ready;

  always_comb begin
    px_r = pixels.pixel[15:11];
    px_g = pixels.pixel[10:5];
    px_b = pixels.pixel[4:0];
    rg_diff  = $signed({3'b000, px_r, 1'b0}) - $signed({3'b000, px_g});
    rg_limit = $signed({2'b00, red_green_margin, 1'b0});
    rb_diff  = $signed({2'b00, px_r}) - $signed({2'b00, px_b});
    rb_limit = $signed({2'b00, red_blue_margin});
    obj = (px_r > red_min) && (rg_diff > rg_limit) && (rb_diff > rb_limit);

    // bounding box with this pixel included
    box_left_next   = box_left;
    box_right_next  = box_right;
    box_top_next    = box_top;
    box_bottom_next = box_bottom;
    if (obj) begin
      if (!seen_object) begin
        box_left_next   = column_count;
        box_right_next  = column_count;
        box_top_next    = row_count;
        box_bottom_next = row_count;
      end else begin
        if (column_count < box_left)  box_left_next   = column_count;
        if (column_count > box_right) box_right_next  = column_count;
        if (row_count < box_top)      box_top_next    = row_count;
        if (row_count > box_bottom)   box_bottom_next = row_count;
      end
    end

    // raster counters
    col_inc = {1'b0, column_count} + (CW + 1)'(1);
    if (CMP_W'(col_inc) >= CMP_W'(line_width)) begin
      column_count_next = '0;
      row_count_next    = row_count + CW'(1);
    end else begin
      column_count_next = col_inc[CW-1:0];
      row_count_next    = row_count;
    end

    // frame summary and servo step
    sum_x  = {1'b0, box_left_next} + {1'b0, box_right_next};
    sum_y  = {1'b0, box_top_next} + {1'b0, box_bottom_next};
    cx     = '0;
    cy     = '0;
    cx_ext = CMP_W'(sum_x[CW:1]);
    servo_sum = '0;
    servo_position_next = servo_position;
    if (pixels.end_of_frame) begin
      cx = sum_x[CW:1];
      cy = sum_y[CW:1];
      if (cx == '0) begin
        servo_sum = {1'b0, servo_position} + (SERVO_W + 1)'(lost_step);
        servo_position_next = (servo_sum > {1'b0, SERVO_MAX}) ? SERVO_MAX
                                                             : servo_sum[SERVO_W-1:0];
      end else if (cx_ext < CMP_W'(center_low)) begin
        if (servo_position < SERVO_MAX) servo_position_next = servo_position + SERVO_W'(1);
      end else if (cx_ext > CMP_W'(center_high) && cx_ext < CMP_W'(line_width)) begin
        if (servo_position != '0) servo_position_next = servo_position - SERVO_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      row_count      <= '0;
      seen_object    <= 1'b0;
      box_left       <= '0;
      box_right      <= '0;
      box_top        <= '0;
      box_bottom     <= '0;
      servo_position <= servo_reset_init();
    end else if (push) begin
      servo_position <= servo_position_next;
      if (pixels.end_of_frame) begin
        column_count <= '0;
        row_count    <= '0;
        seen_object  <= 1'b0;
        box_left     <= '0;
        box_right    <= '0;
        box_top      <= '0;
        box_bottom   <= '0;
      end else begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        seen_object  <= seen_object || obj;
        box_left     <= box_left_next;
        box_right    <= box_right_next;
        box_top      <= box_top_next;
        box_bottom   <= box_bottom_next;
      end
    end
  end

  function automatic logic [SERVO_W-1:0] servo_reset_init();
    return SERVO_RESET_RST;
  endfunction

  // output register and skid register
  logic               out_valid, out_obj, out_done;
  logic [CW-1:0]      out_cx, out_cy;
  logic [SERVO_W-1:0] out_servo;
  logic               skid_valid, skid_obj, skid_done;
  logic [CW-1:0]      skid_cx, skid_cy;
  logic [SERVO_W-1:0] skid_servo;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= push;
      end else begin
        out_valid <= push;
      end
    end else if (!out_valid) begin
      out_valid <= push;
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if ((pop && skid_valid) || (out_valid && !pop && push)) begin
      skid_obj   <= obj;
      skid_done  <= pixels.end_of_frame;
      skid_cx    <= cx;
      skid_cy    <= cy;
      skid_servo <= servo_position_next;
    end
    if (pop && skid_valid) begin
      out_obj   <= skid_obj;
      out_done  <= skid_done;
      out_cx    <= skid_cx;
      out_cy    <= skid_cy;
      out_servo <= skid_servo;
    end else if (pop || !out_valid) begin
      out_obj   <= obj;
      out_done  <= pixels.end_of_frame;
      out_cx    <= cx;
      out_cy    <= cy;
      out_servo <= servo_position_next;
    end
  end

  assign pixels.ready         = !skid_valid;
  assign results.valid        = out_valid;
  assign results.marked_pixel = out_obj ? OBJECT_MARK : '0;
  assign results.frame_done   = out_done;
  assign results.center_x     = out_cx;
  assign results.center_y     = out_cy;
  assign results.servo_value  = out_servo;

  `CBT_ASSERT_IMP(a_skid_behind_out, skid_valid, out_valid)
  `CBT_ASSERT_IMP(a_servo_range, out_valid, out_servo <= SERVO_MAX)
  `CBT_ASSERT_IMP(a_center_only_on_frame, out_valid && !out_done,
                  out_cx == '0 && out_cy == '0)
  `CBT_ASSERT_NXT(a_frame_cleared, push && pixels.end_of_frame,
                  !seen_object && column_count == '0 && row_count == '0)
  `CBT_ASSERT_IMP(a_servo_reset_clamped, 1'b1, servo_reset <= SERVO_MAX)

endmodule

@@ tb/testbench.sv @@
// testbench for the red blob bounding box tracker: predicted results checked item by item
`timescale 1ns / 1ps
module testbench;
  import cbt_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic [PIXEL_W-1:0] marked_pixel;
    logic               frame_done;
    logic [CB-1:0]      center_x;
    logic [CB-1:0]      center_y;
    logic [SERVO_W-1:0] servo_value;
  } tracker_result_t;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  cbt_pixel_if pix ();
  cbt_result_if #(.COORD_BITS(CB)) res ();

  color_blob_bbox_tracker #(.COORD_BITS(CB)) dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixels    (pix),
    .results   (res)
  );

  // register copies
  logic [9:0]  line_len;
  logic [4:0]  red_floor;
  logic [5:0]  rg_margin;
  logic [4:0]  rb_margin;
  logic [9:0]  band_low;
  logic [9:0]  band_high;
  logic [7:0]  lost_inc;

  // tracker state
  logic [CB-1:0]      col_pos, row_pos;
  logic [CB-1:0]      box_l, box_r, box_t, box_b;
  logic               blob_seen;
  logic [SERVO_W-1:0] servo_pos;

  tracker_result_t pending_results[$];

  int errors;
  int cycle_count;
  int pixels_sent;
  int frames_sent;
  int object_pixels;
  int reg_writes;
  int servo_lo;
  int servo_hi;
  int send_gap_pct;
  int recv_stall_pct;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [PIXEL_W-1:0] rgb(int r, int g, int b);
    return {r[4:0], g[5:0], b[4:0]};
  endfunction

  function automatic tracker_result_t track_pixel(logic [PIXEL_W-1:0] px, logic eof);
    tracker_result_t r;
    int red, green, blue;
    int floor_i, rg_i, rb_i, len_i;
    int next_col, mid_x, mid_y, s;
    logic hit;
    red = int'(px[15:11]);
    green = int'(px[10:5]);
    blue = int'(px[4:0]);
    floor_i = int'(red_floor);
    rg_i = int'(rg_margin);
    rb_i = int'(rb_margin);
    len_i = int'(line_len);
    hit = (red > floor_i) && (2 * red - green > 2 * rg_i) && (red - blue > rb_i);
    if (hit) begin
      object_pixels++;
      if (!blob_seen) begin
        box_l = col_pos;
        box_r = col_pos;
        box_t = row_pos;
        box_b = row_pos;
        blob_seen = 1'b1;
      end else begin
        if (col_pos < box_l) box_l = col_pos;
        if (col_pos > box_r) box_r = col_pos;
        if (row_pos < box_t) box_t = row_pos;
        if (row_pos > box_b) box_b = row_pos;
      end
    end
    next_col = int'(col_pos) + 1;
    if (next_col >= len_i) begin
      col_pos = '0;
      row_pos = row_pos + CB'(1);
    end else begin
      col_pos = next_col[CB-1:0];
    end
    mid_x = 0;
    mid_y = 0;
    if (eof) begin
      mid_x = ((int'(box_l) + int'(box_r)) >> 1) & ((1 << CB) - 1);
      mid_y = ((int'(box_t) + int'(box_b)) >> 1) & ((1 << CB) - 1);
      s = int'(servo_pos);
      if (mid_x == 0) begin
        s = s + int'(lost_inc);
        if (s > int'(SERVO_MAX)) s = int'(SERVO_MAX);
      end else if (mid_x < int'(band_low)) begin
        if (s < int'(SERVO_MAX)) s++;
      end else if (mid_x > int'(band_high) && mid_x < len_i) begin
        if (s > 0) s--;
      end
      servo_pos = s[SERVO_W-1:0];
      if (s < servo_lo) servo_lo = s;
      if (s > servo_hi) servo_hi = s;
      col_pos = '0;
      row_pos = '0;
      blob_seen = 1'b0;
      box_l = '0;
      box_r = '0;
      box_t = '0;
      box_b = '0;
    end
    r.marked_pixel = hit ? OBJECT_MARK : '0;
    r.frame_done = eof;
    r.center_x = mid_x[CB-1:0];
    r.center_y = mid_y[CB-1:0];
    r.servo_value = servo_pos;
    return r;
  endfunction

  task automatic send_pixel(logic [PIXEL_W-1:0] px, logic eof);
    while ($urandom_range(99) < send_gap_pct) begin
      pix.valid <= 1'b0;
      @(negedge clk);
    end
    pix.valid <= 1'b1;
    pix.pixel <= px;
    pix.end_of_frame <= eof;
    @(posedge clk);
    while (!pix.ready) @(posedge clk);
    pending_results.push_back(track_pixel(px, eof));
    pixels_sent++;
    if (eof) frames_sent++;
    @(negedge clk);
  endtask

  // stop sending and let every result come back
  task automatic drain();
    pix.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
    reg_writes++;
    case (idx)
      REG_LINE_WIDTH:  line_len = val[9:0];
      REG_RED_MIN:     red_floor = val[4:0];
      REG_RG_MARGIN:   rg_margin = val[5:0];
      REG_RB_MARGIN:   rb_margin = val[4:0];
      REG_CENTER_LOW:  band_low = val[9:0];
      REG_CENTER_HIGH: band_high = val[9:0];
      REG_LOST_STEP:   lost_inc = val[7:0];
      // only reset loads the servo, and reset restores this register too
      REG_SERVO_RESET: ;
      default: ;
    endcase
  endtask

  function automatic logic [PIXEL_W-1:0] random_pixel(int obj_pct);
    if ($urandom_range(99) < obj_pct)
      return rgb($urandom_range(31, 12), $urandom_range(24), $urandom_range(12));
    return PIXEL_W'($urandom());
  endfunction

  task automatic send_frame(int len, int obj_pct, int red_at);
    for (int i = 0; i < len; i++) begin
      send_pixel(i == red_at ? rgb(31, 0, 0) : random_pixel(obj_pct), i == len - 1);
    end
  endtask

  function automatic int pick(int lo, int hi);
    if ($urandom_range(4) == 0) return $urandom_range(1) ? hi : lo;
    return $urandom_range(hi, lo);
  endfunction

  task automatic randomize_regs();
    case ($urandom_range(9))
      0: write_reg(REG_LINE_WIDTH, 0);
      1: write_reg(REG_LINE_WIDTH, 1);
      2: write_reg(REG_LINE_WIDTH, 1023);
      default: write_reg(REG_LINE_WIDTH, $urandom_range(24, 2));
    endcase
    write_reg(REG_RED_MIN, pick(0, 31));
    write_reg(REG_RG_MARGIN, pick(0, 63));
    write_reg(REG_RB_MARGIN, pick(0, 31));
    write_reg(REG_CENTER_LOW, $urandom_range(5) == 0 ? 1023 : $urandom_range(line_len + 1));
    write_reg(REG_CENTER_HIGH, $urandom_range(5) == 0 ? 0 : $urandom_range(line_len + 1));
    write_reg(REG_LOST_STEP, pick(0, 255));
    write_reg(REG_SERVO_RESET, pick(0, 2047));
  endtask

  task automatic test_classify_and_steer();
    drain();
    write_reg(REG_LINE_WIDTH, 4);
    write_reg(REG_CENTER_LOW, 2);
    write_reg(REG_CENTER_HIGH, 2);
    // thresholds on each side, box center x 1
    send_pixel(16'hFFFF, 1'b0);
    send_pixel(rgb(16, 0, 0), 1'b0);
    send_pixel(rgb(15, 0, 0), 1'b0);
    send_pixel(rgb(20, 28, 0), 1'b0);
    send_pixel(rgb(20, 27, 0), 1'b0);
    send_pixel(rgb(20, 0, 14), 1'b0);
    send_pixel(rgb(20, 0, 13), 1'b1);
    // nothing found
    send_pixel(16'h0000, 1'b1);
    // object only at column zero
    send_pixel(rgb(31, 0, 0), 1'b1);
    // left of, inside and right of the dead band
    send_frame(2, 0, 1);
    send_frame(3, 0, 2);
    send_frame(4, 0, 3);
    // zero line width keeps every pixel in column zero
    drain();
    write_reg(REG_LINE_WIDTH, 0);
    send_pixel(rgb(31, 0, 0), 1'b0);
    send_pixel(16'h0000, 1'b0);
    send_pixel(rgb(31, 0, 0), 1'b1);
  endtask

  task automatic test_servo_limits();
    drain();
    write_reg(REG_LINE_WIDTH, 2);
    write_reg(REG_CENTER_LOW, 0);
    write_reg(REG_CENTER_HIGH, 0);
    write_reg(REG_LOST_STEP, 0);
    send_pixel(16'h0000, 1'b1);
    while (servo_pos != 0) send_frame(2, 0, 1);
    repeat (2) send_frame(2, 0, 1);
    drain();
    write_reg(REG_LOST_STEP, 255);
    write_reg(REG_CENTER_LOW, 1023);
    while (servo_pos != SERVO_MAX) send_pixel(16'h0000, 1'b1);
    send_pixel(16'h0000, 1'b1);
    repeat (2) send_frame(2, 0, 1);
  endtask

  task automatic test_wide_line();
    drain();
    write_reg(REG_LINE_WIDTH, 1023);
    write_reg(REG_RED_MIN, 15);
    write_reg(REG_RG_MARGIN, 6);
    write_reg(REG_RB_MARGIN, 6);
    write_reg(REG_CENTER_LOW, 300);
    write_reg(REG_CENTER_HIGH, 700);
    send_frame(150, 1, 140);
  endtask

  task automatic test_tall_frame();
    drain();
    write_reg(REG_LINE_WIDTH, 1);
    write_reg(REG_RED_MIN, 0);
    write_reg(REG_RG_MARGIN, 0);
    write_reg(REG_RB_MARGIN, 0);
    send_frame(150, 1, 120);
  endtask

  task automatic test_random(int n_items);
    int start_count;
    int len_cap;
    int obj_pct;
    start_count = pixels_sent;
    while (pixels_sent - start_count < n_items) begin
      drain();
      randomize_regs();
      obj_pct = $urandom_range(40);
      len_cap = (line_len < 2) ? 20 : (line_len > 20 ? 60 : 3 * int'(line_len));
      repeat ($urandom_range(8, 3)) begin
        if ($urandom_range(9) == 0)
          send_frame(1, obj_pct, -1);
        else
          send_frame($urandom_range(len_cap, 1), obj_pct, -1);
      end
    end
  endtask

  initial begin
    res.ready = 1'b0;
    forever begin
      @(negedge clk);
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    tracker_result_t want;
    if (!rst && res.valid && res.ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual marked_pixel %h", $time,
                 res.marked_pixel);
        errors++;
      end else begin
        want = pending_results.pop_front();
        compare_field("marked_pixel", want.marked_pixel, res.marked_pixel);
        compare_field("frame_done", 16'(want.frame_done), 16'(res.frame_done));
        compare_field("center_x", 16'(want.center_x), 16'(res.center_x));
        compare_field("center_y", 16'(want.center_y), 16'(res.center_y));
        compare_field("servo_value", 16'(want.servo_value), 16'(res.servo_value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d items outstanding", cycle_count,
               pending_results.size());
      $display("** color_blob_bbox_tracker: FAILED **");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_LINE_WIDTH;
    cfg_data = '0;
    pix.valid = 1'b0;
    pix.pixel = '0;
    pix.end_of_frame = 1'b0;
    errors = 0;
    cycle_count = 0;
    pixels_sent = 0;
    frames_sent = 0;
    object_pixels = 0;
    reg_writes = 0;
    line_len = LINE_WIDTH_RST;
    red_floor = RED_MIN_RST;
    rg_margin = RG_MARGIN_RST;
    rb_margin = RB_MARGIN_RST;
    band_low = CENTER_LOW_RST;
    band_high = CENTER_HIGH_RST;
    lost_inc = LOST_STEP_RST;
    col_pos = '0;
    row_pos = '0;
    blob_seen = 1'b0;
    box_l = '0;
    box_r = '0;
    box_t = '0;
    box_b = '0;
    servo_pos = SERVO_RESET_RST;
    servo_lo = int'(servo_pos);
    servo_hi = int'(servo_pos);
    send_gap_pct = 24;
    recv_stall_pct = 45;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_classify_and_steer();
    test_servo_limits();
    test_random(100);
    send_gap_pct = 45;
    recv_stall_pct = 24;
    test_wide_line();
    test_random(100);
    send_gap_pct = 0;
    recv_stall_pct = 0;
    test_tall_frame();
    test_random(100);

    drain();
    repeat (10) @(negedge clk);
    $display("covered %0d pixels in %0d frames, %0d classed as object, %0d register writes",
             pixels_sent, frames_sent, object_pixels, reg_writes);
    $display("servo swept %0d..%0d under three handshake pressure settings", servo_lo,
             servo_hi);
    if (errors == 0) begin
      $display("** color_blob_bbox_tracker: PASSED **");
    end else begin
      $display("** color_blob_bbox_tracker: FAILED **");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/cbt_pkg.sv
design/cbt_pixel_if.sv
design/cbt_result_if.sv
design/color_blob_bbox_tracker.sv
tb/testbench.sv
